[design/tcprr_pkg.sv]
// Shared constants and types for the TCP receive reassembly block.
package tcprr_pkg;

   // The store depth must be a power of two.
   localparam int STORE_BYTES_DEF = 4096;

   localparam logic [1:0] ST_IN_ORDER = 2'd0;
   localparam logic [1:0] ST_OUT_OF_ORDER = 2'd1;
   localparam logic [1:0] ST_DUPLICATE = 2'd2;
   localparam logic [1:0] ST_CAPACITY = 2'd3;

   typedef struct packed {
      logic wr_en;
      logic wr_bit;
      logic rd_en;
   } pend_ctl_type;

endpackage

[design/tcprr_if.sv]
// Valid/ready channel interfaces for segment bytes and segment results.
interface tcprr_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] seq_num;
   logic [15:0] seg_len;
   logic [15:0] byte_offset;
   logic [7:0]  data_byte;
   logic        last_byte;
   logic [31:0] read_pointer;

   modport source(output valid, seq_num, seg_len, byte_offset, data_byte, last_byte,
                  read_pointer, input ready);
   modport sink(input valid, seq_num, seg_len, byte_offset, data_byte, last_byte,
                read_pointer, output ready);
endinterface

interface tcprr_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [31:0] ack_number;
   logic        send_ack;

   modport source(output valid, status, ack_number, send_ack, input ready);
   modport sink(input valid, status, ack_number, send_ack, output ready);
endinterface

[design/tcprr_store.sv]
// Byte memory that holds accepted segment payload.
module tcprr_store import tcprr_pkg::*; #(
   parameter int STORE_BYTES = STORE_BYTES_DEF,
   localparam int IDX_W = $clog2(STORE_BYTES)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_addr,
   input  logic [7:0]       wr_data
);

   logic [7:0] mem [STORE_BYTES];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

endmodule

[design/tcprr_pend_ram.sv]
// Pending bitmap memory with one write port and one registered read port.
module tcprr_pend_ram import tcprr_pkg::*; #(
   parameter int STORE_BYTES = STORE_BYTES_DEF,
   localparam int IDX_W = $clog2(STORE_BYTES)
) (
   input  logic             clock,
   input  pend_ctl_type     ctl,
   input  logic [IDX_W-1:0] wr_addr,
   input  logic [IDX_W-1:0] rd_addr,
   output logic             rd_data
);

   logic mem [STORE_BYTES];
   logic rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[wr_addr] <= ctl.wr_bit;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[design/tcprr_ctrl.sv]
// Segment classification, sequence state and pending-run sequencer.
module tcprr_ctrl import tcprr_pkg::*; #(
   parameter int STORE_BYTES = STORE_BYTES_DEF,
   localparam int IDX_W = $clog2(STORE_BYTES)
) (
   input  logic             clock,
   input  logic             reset,
   tcprr_req_if.sink        req_chan,
   tcprr_rsp_if.source      rsp_chan,
   input  logic             csr_we,
   input  logic [31:0]      csr_wdata,
   output logic             st_we,
   output logic [IDX_W-1:0] st_addr,
   output logic [7:0]       st_data,
   output pend_ctl_type     pend_ctl,
   output logic [IDX_W-1:0] pend_waddr,
   output logic [IDX_W-1:0] pend_raddr,
   input  logic             pend_rdata
);

   localparam logic [1:0] S_CLEAR = 2'd0;
   localparam logic [1:0] S_IDLE = 2'd1;
   localparam logic [1:0] S_RD = 2'd2;
   localparam logic [1:0] S_CHK = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic [IDX_W-1:0] clr_addr_ff, clr_addr_in;
   logic [31:0]      next_exp_ff, next_exp_in;
   logic [31:0]      high_rcv_ff, high_rcv_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [1:0]       rsp_status_ff, rsp_status_in;
   logic [31:0]      rsp_ack_ff, rsp_ack_in;
   logic             rsp_send_ff, rsp_send_in;

   logic [31:0] last_seq;
   logic [31:0] diff_ne;
   logic [31:0] diff_hr;
   logic [31:0] diff_last;
   logic [31:0] span;
   logic [31:0] byte_seq;
   logic        is_dup;
   logic        above_hr;
   logic        last_above;
   logic        no_room;
   logic [1:0]  status;
   logic        keep;
   logic        in_range;
   logic        accept;

   assign last_seq = req_chan.seq_num + {16'd0, req_chan.seg_len} - 32'd1;
   assign diff_ne = req_chan.seq_num - next_exp_ff;
   assign diff_hr = req_chan.seq_num - high_rcv_ff;
   assign diff_last = last_seq - high_rcv_ff;
   assign span = last_seq - req_chan.read_pointer;
   assign byte_seq = req_chan.seq_num + {16'd0, req_chan.byte_offset};

   assign is_dup = (req_chan.seq_num != 32'd0) && diff_ne[31];
   assign above_hr = (diff_hr != 32'd0) && !diff_hr[31];
   assign last_above = (diff_last != 32'd0) && !diff_last[31];
   assign no_room = |span[31:IDX_W];
   assign in_range = req_chan.byte_offset < req_chan.seg_len;

   always_comb begin
      if (is_dup) begin
         status = ST_DUPLICATE;
      end else if (above_hr && no_room) begin
         status = ST_CAPACITY;
      end else if (diff_ne == 32'd0) begin
         status = ST_IN_ORDER;
      end else begin
         status = ST_OUT_OF_ORDER;
      end
   end

   assign keep = (status == ST_IN_ORDER) || (status == ST_OUT_OF_ORDER);
   assign req_chan.ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_chan.ready);
   assign accept = req_chan.valid && req_chan.ready;

   assign st_we = accept && keep && in_range;
   assign st_addr = byte_seq[IDX_W-1:0];
   assign st_data = req_chan.data_byte;

   assign pend_raddr = next_exp_ff[IDX_W-1:0];

   always_comb begin
      pend_ctl.wr_en = 1'b0;
      pend_ctl.wr_bit = 1'b0;
      pend_ctl.rd_en = (state_ff == S_RD);
      pend_waddr = next_exp_ff[IDX_W-1:0];
      case (state_ff)
         S_CLEAR: begin
            pend_ctl.wr_en = 1'b1;
            pend_waddr = clr_addr_ff;
         end
         S_IDLE: begin
            pend_ctl.wr_en = st_we && (status == ST_OUT_OF_ORDER);
            pend_ctl.wr_bit = 1'b1;
            pend_waddr = byte_seq[IDX_W-1:0];
         end
         S_CHK: begin
            pend_ctl.wr_en = pend_rdata;
         end
         default: begin
            pend_ctl.wr_en = 1'b0;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      clr_addr_in = clr_addr_ff;
      next_exp_in = next_exp_ff;
      high_rcv_in = high_rcv_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in = rsp_status_ff;
      rsp_ack_in = rsp_ack_ff;
      rsp_send_in = rsp_send_ff;
      case (state_ff)
         S_CLEAR: begin
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == IDX_W'(STORE_BYTES - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept && req_chan.last_byte) begin
               if (keep && last_above) begin
                  high_rcv_in = last_seq;
               end
               if (status == ST_IN_ORDER) begin
                  next_exp_in = last_seq + 32'd1;
                  state_in = S_RD;
               end else begin
                  rsp_valid_in = 1'b1;
                  rsp_status_in = status;
                  rsp_ack_in = next_exp_ff;
                  rsp_send_in = 1'b0;
               end
            end
         end
         S_RD: begin
            state_in = S_CHK;
         end
         S_CHK: begin
            if (pend_rdata) begin
               next_exp_in = next_exp_ff + 32'd1;
               state_in = S_RD;
            end else begin
               rsp_valid_in = 1'b1;
               rsp_status_in = ST_IN_ORDER;
               rsp_ack_in = next_exp_ff;
               rsp_send_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
      if (csr_we) begin
         next_exp_in = csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_addr_ff <= '0;
         next_exp_ff <= 32'd0;
         high_rcv_ff <= 32'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_addr_ff <= clr_addr_in;
         next_exp_ff <= next_exp_in;
         high_rcv_ff <= high_rcv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_ack_ff <= rsp_ack_in;
      rsp_send_ff <= rsp_send_in;
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.status = rsp_status_ff;
   assign rsp_chan.ack_number = rsp_ack_ff;
   assign rsp_chan.send_ack = rsp_send_ff;

endmodule

[design/tcp_receive_reassembly.sv]
// Top level of the TCP receive reassembly block.
//
// Segment payload enters on req_chan one byte per item; every item repeats the
// segment's sequence number, payload length and the reader's position. One
// result item leaves on rsp_chan for each item marked last_byte, carrying the
// status, the acknowledgment number and the send_ack flag. csr_we loads the
// expected sequence number and may be written at any time the block is idle.
// After reset the block clears every entry of the pending bitmap with
// req_chan.ready low; configuration writes are taken during the sweep.
// Bytes that are not the last of a segment are taken one per cycle unless a
// result is stalled. A last item of a dropped or out-of-order segment gives
// its result in the next cycle. A last item of an in-order segment walks the
// pending bitmap through its single read port, clearing pending bytes in turn
// until it reads an entry that is not set; only then comes its result, and no
// item is taken meanwhile. The result sits in an output register; while it is
// not taken, req_chan.ready stays low. STORE_BYTES must be a power of two.
module tcp_receive_reassembly import tcprr_pkg::*; #(
   parameter int STORE_BYTES = STORE_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   tcprr_req_if.sink   req_chan,
   tcprr_rsp_if.source rsp_chan,
   input  logic        csr_we,
   input  logic [31:0] csr_wdata
);

   localparam int IDX_W = $clog2(STORE_BYTES);

   logic             st_we;
   logic [IDX_W-1:0] st_addr;
   logic [7:0]       st_data;
   pend_ctl_type     pend_ctl;
   logic [IDX_W-1:0] pend_waddr;
   logic [IDX_W-1:0] pend_raddr;
   logic             pend_rdata;

   tcprr_ctrl #(.STORE_BYTES(STORE_BYTES)) u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan),
      .csr_we(csr_we),
      .csr_wdata(csr_wdata),
      .st_we(st_we),
      .st_addr(st_addr),
      .st_data(st_data),
      .pend_ctl(pend_ctl),
      .pend_waddr(pend_waddr),
      .pend_raddr(pend_raddr),
      .pend_rdata(pend_rdata)
   );

   tcprr_store #(.STORE_BYTES(STORE_BYTES)) u_store (
      .clock(clock),
      .wr_en(st_we),
      .wr_addr(st_addr),
      .wr_data(st_data)
   );

   tcprr_pend_ram #(.STORE_BYTES(STORE_BYTES)) u_pend (
      .clock(clock),
      .ctl(pend_ctl),
      .wr_addr(pend_waddr),
      .rd_addr(pend_raddr),
      .rd_data(pend_rdata)
   );

endmodule

[design/tcprr_checker.sv]
// Port-level checks for the TCP receive reassembly block and their binding.
module tcprr_checker import tcprr_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       req_last_byte,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_status,
   input logic       rsp_send_ack
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
      else $error("Result item changed while stalled.");

   a_ack_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_send_ack == (rsp_status == ST_IN_ORDER)))
      else $error("send_ack does not match the in-order status.");

   a_no_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !req_last_byte |=> !rsp_valid)
      else $error("Result item given for an item that is not last.");

   a_reset_sweep: assert property (@(posedge clock)
      $past(reset) |-> !req_ready)
      else $error("Item accepted right after reset.");

endmodule

bind tcp_receive_reassembly tcprr_checker u_tcprr_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req_chan.valid),
   .req_ready(req_chan.ready),
   .req_last_byte(req_chan.last_byte),
   .rsp_valid(rsp_chan.valid),
   .rsp_ready(rsp_chan.ready),
   .rsp_status(rsp_chan.status),
   .rsp_send_ack(rsp_chan.send_ack)
);

[dv/tcprr_tb_pkg.sv]
// Segment verdict predictor and scoreboard for the TCP receive reassembly testbench.
package tcprr_tb_pkg;
   import tcprr_pkg::*;

   typedef struct {
      logic [1:0]  status;
      logic [31:0] ack_number;
      logic        send_ack;
   } seg_verdict_type;

   class reassembly_board_type;
      logic [31:0]     rcv_next;
      logic [31:0]     rcv_highest;
      bit              gap_map[STORE_BYTES_DEF];
      seg_verdict_type verdict_q[$];
      int              errors;
      int              checked;
      int              by_status[4];

      function new();
         rcv_next = '0;
         rcv_highest = '0;
         errors = 0;
         checked = 0;
         foreach (gap_map[i]) gap_map[i] = 1'b0;
         foreach (by_status[i]) by_status[i] = 0;
      endfunction

      function void load_expected(input logic [31:0] value);
         rcv_next = value;
      endfunction

      function int outstanding();
         return verdict_q.size();
      endfunction

      static function bit seq_lt(input logic [31:0] a, input logic [31:0] b);
         logic [31:0] d;
         d = a - b;
         return d[31];
      endfunction

      static function bit seq_gt(input logic [31:0] a, input logic [31:0] b);
         logic [31:0] d;
         d = a - b;
         return (d != 32'd0) && !d[31];
      endfunction

      static function int slot_of(input logic [31:0] s);
         return int'(s % 32'(STORE_BYTES_DEF));
      endfunction

      // Predicts the effect of one accepted byte and queues a verdict on the last one.
      function void take_byte(input logic [31:0] seq, input logic [15:0] len,
                              input logic [15:0] ofs, input logic last,
                              input logic [31:0] rd_ptr);
         logic [31:0]     last_seq;
         logic [31:0]     span;
         logic [1:0]      st;
         int              steps;
         seg_verdict_type v;
         last_seq = seq + {16'd0, len} - 32'd1;
         span = last_seq - rd_ptr;
         if (seq != 32'd0 && seq_lt(seq, rcv_next)) begin
            st = ST_DUPLICATE;
         end else if (seq_gt(seq, rcv_highest) && span >= 32'(STORE_BYTES_DEF)) begin
            st = ST_CAPACITY;
         end else if (seq == rcv_next) begin
            st = ST_IN_ORDER;
         end else begin
            st = ST_OUT_OF_ORDER;
         end
         if (st == ST_OUT_OF_ORDER && ofs < len) begin
            gap_map[slot_of(seq + {16'd0, ofs})] = 1'b1;
         end
         if (!last) return;
         if (st == ST_IN_ORDER || st == ST_OUT_OF_ORDER) begin
            if (st == ST_IN_ORDER) begin
               rcv_next = last_seq + 32'd1;
               steps = 0;
               while (steps < STORE_BYTES_DEF && gap_map[slot_of(rcv_next)]) begin
                  gap_map[slot_of(rcv_next)] = 1'b0;
                  rcv_next = rcv_next + 32'd1;
                  steps++;
               end
            end
            if (seq_gt(last_seq, rcv_highest)) rcv_highest = last_seq;
         end
         v.status = st;
         v.ack_number = rcv_next;
         v.send_ack = (st == ST_IN_ORDER);
         verdict_q.push_back(v);
      endfunction

      task report(input string msg);
         errors++;
         $display("mismatch: %s", msg);
      endtask

      task check_verdict(input logic [1:0] status, input logic [31:0] ack_number,
                         input logic send_ack);
         seg_verdict_type want;
         if (verdict_q.size() == 0) begin
            report($sformatf("result status %0d ack %h arrived with no segment waiting",
                             status, ack_number));
            return;
         end
         want = verdict_q.pop_front();
         checked++;
         by_status[want.status]++;
         if (status !== want.status)
            report($sformatf("result %0d status %0d, expected %0d",
                             checked, status, want.status));
         if (ack_number !== want.ack_number)
            report($sformatf("result %0d ack_number %h, expected %h",
                             checked, ack_number, want.ack_number));
         if (send_ack !== want.send_ack)
            report($sformatf("result %0d send_ack %b, expected %b",
                             checked, send_ack, want.send_ack));
      endtask
   endclass

endpackage

[dv/tcp_receive_reassembly_tb.sv]
// Testbench top for the TCP receive reassembly block.
module tcp_receive_reassembly_tb;
   import tcprr_pkg::*;
   import tcprr_tb_pkg::*;

   localparam int WATCHDOG_LIMIT = 4 * (2 * STORE_BYTES_DEF + 64);
   localparam int SETTLE_CYCLES = 8;
   localparam int DRAIN_CYCLES = 32;
   localparam int PHASE_ITEMS = 290;
   localparam int NUM_PHASES = 6;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [31:0] csr_wdata;
   logic [31:0] start_points[NUM_PHASES];
   bit          calm;
   int          items_sent;
   int          idle_cycles;
   reassembly_board_type board;

   tcprr_req_if req_chan();
   tcprr_rsp_if rsp_chan();

   tcp_receive_reassembly DUT (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan),
      .csr_we(csr_we),
      .csr_wdata(csr_wdata)
   );

   always #6 clock = ~clock;

   task automatic send_byte(input logic [31:0] seq, input logic [15:0] len,
                            input logic [15:0] ofs, input logic [7:0] data,
                            input logic last, input logic [31:0] rd_ptr);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 11);
      if (gap != 0) begin
         req_chan.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid = 1'b1;
      req_chan.seq_num = seq;
      req_chan.seg_len = len;
      req_chan.byte_offset = ofs;
      req_chan.data_byte = data;
      req_chan.last_byte = last;
      req_chan.read_pointer = rd_ptr;
      do @(posedge clock); while (!req_chan.ready);
      board.take_byte(seq, len, ofs, last, rd_ptr);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_segment(input logic [31:0] seq, input logic [15:0] len,
                               input logic [31:0] rd_ptr, input bit truncated);
      if (len == 16'd0) begin
         send_byte(seq, len, 16'($urandom), 8'($urandom), 1'b1, rd_ptr);
      end else begin
         for (int i = 0; i < int'(len); i++)
            send_byte(seq, len, 16'(i), 8'($urandom),
                      (i == int'(len) - 1) && !truncated, rd_ptr);
      end
   endtask

   task automatic settle();
      req_chan.valid = 1'b0;
      while (board.outstanding() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_expected(input logic [31:0] value);
      csr_we = 1'b1;
      csr_wdata = value;
      board.load_expected(value);
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic directed_segments();
      calm = 1'b0;
      send_byte(32'hFFFF_FFF8, 16'd0, 16'd0, 8'h00, 1'b1, 32'hFFFF_FFFF);
      send_segment(32'hFFFF_FFFC, 16'd4, 32'hFFFF_FFF8, 1'b0);
      send_segment(32'hFFFF_FFF8, 16'd4, 32'hFFFF_FFF8, 1'b0);
      send_byte(32'hFFFF_FFF9, 16'd2, 16'd0, 8'h5A, 1'b1, 32'd0);
      send_byte(32'h0000_5000, 16'd16, 16'd15, 8'hA5, 1'b1, 32'd0);
      send_byte(32'd0, 16'd2, 16'hFFFF, 8'h11, 1'b0, 32'd0);
      send_byte(32'd0, 16'd2, 16'd0, 8'h12, 1'b0, 32'd0);
      send_byte(32'd0, 16'd2, 16'd1, 8'h13, 1'b1, 32'd0);
      send_byte(32'd0, 16'd1, 16'd0, 8'h22, 1'b1, 32'd0);
      send_byte(32'd2, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b1, 32'd2);
      send_byte(32'd2, 16'd2, 16'd0, 8'h00, 1'b0, 32'd2);
      send_byte(32'd2, 16'd2, 16'd1, 8'hFF, 1'b1, 32'd2);
   endtask

   task automatic random_traffic(input int quota);
      int          first;
      int          pick;
      int          n;
      logic [31:0] ne;
      logic [15:0] len;
      first = items_sent;
      while (items_sent - first < quota) begin
         pick = $urandom_range(0, 99);
         calm = ($urandom_range(0, 7) == 0);
         ne = board.rcv_next;
         if (pick < 45) begin
            send_segment(ne, 16'($urandom_range(1, 40)), ne - $urandom_range(0, 64),
                         $urandom_range(0, 11) == 0);
         end else if (pick < 73) begin
            send_segment(ne + $urandom_range(1, 700), 16'($urandom_range(1, 24)), ne,
                         $urandom_range(0, 11) == 0);
         end else if (pick < 81) begin
            send_segment(ne - $urandom_range(1, 400), 16'($urandom_range(1, 16)), ne,
                         1'b0);
         end else if (pick < 86) begin
            send_segment(ne + $urandom_range(4100, 70000), 16'($urandom_range(1, 6)), ne,
                         1'b0);
         end else if (pick < 90) begin
            send_segment(($urandom_range(0, 1) == 0) ? ne : ne + $urandom_range(1, 300),
                         16'd0, ne, 1'b0);
         end else if (pick < 94) begin
            len = 16'($urandom_range(0, 65535));
            n = $urandom_range(1, 4);
            for (int k = 0; k < n; k++)
               send_byte(ne + $urandom_range(0, 3), len, 16'($urandom), 8'($urandom),
                         k == n - 1, ne - $urandom_range(0, 70000));
         end else begin
            n = $urandom_range(1, 5);
            for (int k = 0; k < n; k++)
               send_byte($urandom, 16'($urandom), 16'($urandom), 8'($urandom),
                         1'($urandom), $urandom);
         end
      end
   endtask

   initial begin
      rsp_chan.ready = 1'b0;
      wait (reset === 1'b0);
      @(negedge clock);
      forever begin
         int stall;
         stall = calm ? 0 : $urandom_range(0, 11);
         if (stall != 0) begin
            rsp_chan.ready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_chan.ready = 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready)
         board.check_verdict(rsp_chan.status, rsp_chan.ack_number, rsp_chan.send_ack);
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired after %0d cycles without a handshake", idle_cycles);
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      board = new();
      clock = 1'b0;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_wdata = '0;
      calm = 1'b0;
      items_sent = 0;
      idle_cycles = 0;
      req_chan.valid = 1'b0;
      req_chan.seq_num = '0;
      req_chan.seg_len = '0;
      req_chan.byte_offset = '0;
      req_chan.data_byte = '0;
      req_chan.last_byte = 1'b0;
      req_chan.read_pointer = '0;
      start_points[0] = 32'hFFFF_FFF8;
      start_points[1] = 32'h0000_0000;
      start_points[2] = 32'hFFFF_FFFF;
      start_points[3] = 32'h8000_0000;
      start_points[4] = $urandom;
      start_points[5] = 32'h7FFF_FFFF;
      repeat (2) @(negedge clock);
      reset = 1'b0;
      for (int p = 0; p < NUM_PHASES; p++) begin
         settle();
         write_expected(start_points[p]);
         if (p == 0) directed_segments();
         random_traffic(PHASE_ITEMS);
      end
      settle();
      repeat (DRAIN_CYCLES) @(negedge clock);
      $display("sent %0d segment bytes and checked %0d verdicts over %0d starting numbers",
               items_sent, board.checked, NUM_PHASES);
      $display("verdicts: in order %0d, out of order %0d, duplicate %0d, capacity %0d",
               board.by_status[ST_IN_ORDER], board.by_status[ST_OUT_OF_ORDER],
               board.by_status[ST_DUPLICATE], board.by_status[ST_CAPACITY]);
      if (board.errors == 0 && board.outstanding() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
